FILE: rtl/byte_stream_tokenizer_macros.svh
// Assertion macros shared by the checker.
`ifndef BYTE_STREAM_TOKENIZER_MACROS_SVH
`define BYTE_STREAM_TOKENIZER_MACROS_SVH
// Antecedent implies consequent at the next clock edge, outside reset.
`define BST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
// A condition that must hold on every clock edge, outside reset.
`define BST_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error(msg);
`endif

FILE: rtl/bst_pkg.sv
package bst_pkg;

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_STR, M_SESC, M_NUM, M_WORD, M_HALT
    } scan_mode_t;

    localparam logic [4:0] K_END      = 5'd0;
    localparam logic [4:0] K_DIV      = 5'd16;
    localparam logic [4:0] K_COMMENT  = 5'd24;
    localparam logic [4:0] K_STRING   = 5'd25;
    localparam logic [4:0] K_NUMBER   = 5'd26;
    localparam logic [4:0] K_WORD     = 5'd27;
    localparam logic [4:0] K_UNCLOSED = 5'd28;
    localparam logic [4:0] K_UNKNOWN  = 5'd29;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;

    localparam int MAX_RECS = 3;

    // Record as it leaves the front end, 16-bit fields already truncated.
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] offset;
        logic [15:0] length;
        logic [15:0] line;
        logic [15:0] column;
    } rec_t;

    // All records caused by one byte.
    typedef struct packed {
        logic [1:0] count;
        rec_t       r2;
        rec_t       r1;
        rec_t       r0;
    } bundle_t;

    // Punctuator code 1..23 or zero.
    function automatic logic [4:0] punct_code(input logic [7:0] c);
        case (c)
            8'h21: punct_code = 5'd1;
            8'h2E: punct_code = 5'd2;
            8'h2C: punct_code = 5'd3;
            8'h3B: punct_code = 5'd4;
            8'h3A: punct_code = 5'd5;
            8'h3D: punct_code = 5'd6;
            8'h5B: punct_code = 5'd7;
            8'h5D: punct_code = 5'd8;
            8'h7B: punct_code = 5'd9;
            8'h7D: punct_code = 5'd10;
            8'h28: punct_code = 5'd11;
            8'h29: punct_code = 5'd12;
            8'h2B: punct_code = 5'd13;
            8'h2D: punct_code = 5'd14;
            8'h2A: punct_code = 5'd15;
            8'h2F: punct_code = 5'd16;
            8'h25: punct_code = 5'd17;
            8'h3E: punct_code = 5'd18;
            8'h3C: punct_code = 5'd19;
            8'h7C: punct_code = 5'd20;
            8'h26: punct_code = 5'd21;
            8'h5E: punct_code = 5'd22;
            8'h3F: punct_code = 5'd23;
            default: punct_code = 5'd0;
        endcase
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

endpackage

FILE: rtl/bst_front.sv
module bst_front import bst_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_end,
    output logic       q_valid,
    input  logic       q_ready,
    output bundle_t    q_data
);
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] ONE  = COUNT_BITS'(1);

    scan_mode_t             mode_reg, mode_next;
    logic                   quote_reg, quote_next;
    logic [COUNT_BITS-1:0]  ts_reg, ts_next, tl_reg, tl_next;
    logic [COUNT_BITS-1:0]  tln_reg, tln_next, tc_reg, tc_next;
    logic [COUNT_BITS-1:0]  off_reg, off_next, ln_reg, ln_next, col_reg, col_next;
    logic                   bv_reg;
    bundle_t                b_reg, b_next;

    function automatic logic [COUNT_BITS-1:0] sinc(input logic [COUNT_BITS-1:0] v);
        sinc = (v == CMAX) ? v : v + ONE;
    endfunction

    function automatic rec_t mk(input logic [4:0] k, input logic [COUNT_BITS-1:0] o,
                                input logic [COUNT_BITS-1:0] l,
                                input logic [COUNT_BITS-1:0] n,
                                input logic [COUNT_BITS-1:0] c);
        mk.kind   = k;
        mk.offset = 16'(o);
        mk.length = 16'(l);
        mk.line   = 16'(n);
        mk.column = 16'(c);
    endfunction

    logic accept;
    assign in_ready = !bv_reg || q_ready;
    assign accept   = in_valid && in_ready;
    assign q_valid  = bv_reg;
    assign q_data   = b_reg;

    always_comb begin
        logic [COUNT_BITS-1:0] col;
        logic                  fresh;
        logic [4:0]            pc;
        rec_t                  recs [MAX_RECS];
        logic [1:0]            n;
        logic [7:0]            qc;
        col = sinc(col_reg);
        fresh = 1'b0;
        n = 2'd0;
        for (int i = 0; i < MAX_RECS; i++) recs[i] = '0;
        mode_next = mode_reg;
        quote_next = quote_reg;
        ts_next = ts_reg; tl_next = tl_reg; tln_next = tln_reg; tc_next = tc_reg;
        qc = quote_reg ? CH_SQ : CH_DQ;
        pc = punct_code(in_byte);
        unique case (mode_reg)
            M_IDLE: fresh = 1'b1;
            M_SLASH: begin
                if (in_byte == CH_SLASH) begin
                    mode_next = M_LINE; tl_next = COUNT_BITS'(2);
                end else if (in_byte == CH_STAR) begin
                    mode_next = M_BLOCK; tl_next = COUNT_BITS'(2);
                end else begin
                    recs[0] = mk(K_DIV, ts_reg, tl_reg, tln_reg, tc_reg); n = 2'd1;
                    fresh = 1'b1;
                end
            end
            M_LINE: begin
                if (in_byte == CH_NL) begin
                    recs[0] = mk(K_COMMENT, ts_reg, tl_reg, tln_reg, tc_reg); n = 2'd1;
                    fresh = 1'b1;
                end else tl_next = sinc(tl_reg);
            end
            M_BLOCK, M_BSTAR: begin
                tl_next = sinc(tl_reg);
                if (mode_reg == M_BSTAR && in_byte == CH_SLASH) begin
                    recs[0] = mk(K_COMMENT, ts_reg, tl_next, tln_reg, tc_reg); n = 2'd1;
                    mode_next = M_IDLE;
                end else mode_next = (in_byte == CH_STAR) ? M_BSTAR : M_BLOCK;
            end
            M_STR: begin
                if (in_byte == qc) begin
                    recs[0] = mk(K_STRING, ts_reg + ONE, tl_reg, tln_reg, tc_reg); n = 2'd1;
                    mode_next = M_IDLE;
                end else begin
                    tl_next = sinc(tl_reg);
                    if (in_byte == CH_BSL) mode_next = M_SESC;
                end
            end
            M_SESC: begin
                tl_next = sinc(tl_reg);
                mode_next = (in_byte == CH_BSL) ? M_SESC : M_STR;
            end
            M_NUM: begin
                if (is_digit(in_byte)) tl_next = sinc(tl_reg);
                else begin
                    recs[0] = mk(K_NUMBER, ts_reg, tl_reg, tln_reg, tc_reg); n = 2'd1;
                    fresh = 1'b1;
                end
            end
            M_WORD: begin
                if (is_alpha(in_byte) || is_digit(in_byte) || in_byte == CH_UNDER)
                    tl_next = sinc(tl_reg);
                else begin
                    recs[0] = mk(K_WORD, ts_reg, tl_reg, tln_reg, tc_reg); n = 2'd1;
                    fresh = 1'b1;
                end
            end
            default: mode_next = M_HALT;
        endcase
        if (fresh) begin
            mode_next = M_IDLE;
            if (is_space(in_byte)) begin
            end else if (in_byte == CH_SLASH) begin
                mode_next = M_SLASH; ts_next = off_reg; tl_next = ONE;
                tln_next = ln_reg; tc_next = col;
            end else if (pc != 5'd0) begin
                recs[n] = mk(pc, off_reg, ONE, ln_reg, col); n = n + 2'd1;
            end else if (in_byte == CH_DQ || in_byte == CH_SQ) begin
                mode_next = M_STR; ts_next = off_reg; tl_next = '0;
                tln_next = ln_reg; tc_next = col; quote_next = (in_byte == CH_SQ);
            end else if (is_digit(in_byte)) begin
                mode_next = M_NUM; ts_next = off_reg; tl_next = ONE;
                tln_next = ln_reg; tc_next = col;
            end else if (is_alpha(in_byte) || in_byte == CH_UNDER) begin
                mode_next = M_WORD; ts_next = off_reg; tl_next = ONE;
                tln_next = ln_reg; tc_next = col;
            end else begin
                recs[n] = mk(K_UNKNOWN, off_reg, ONE, ln_reg, col); n = n + 2'd1;
                mode_next = M_HALT;
            end
        end
        off_next = sinc(off_reg);
        if (in_byte == CH_NL) begin
            ln_next = sinc(ln_reg); col_next = '0;
        end else begin
            ln_next = ln_reg; col_next = col;
        end
        if (in_end) begin
            case (mode_next)
                M_SLASH: begin
                    recs[n] = mk(K_DIV, ts_next, tl_next, tln_next, tc_next); n = n + 2'd1;
                end
                M_LINE, M_BLOCK, M_BSTAR: begin
                    recs[n] = mk(K_COMMENT, ts_next, tl_next, tln_next, tc_next);
                    n = n + 2'd1;
                end
                M_STR, M_SESC: begin
                    recs[n] = mk(K_UNCLOSED, ts_next, sinc(tl_next), tln_next, tc_next);
                    n = n + 2'd1;
                end
                M_NUM: begin
                    recs[n] = mk(K_NUMBER, ts_next, tl_next, tln_next, tc_next); n = n + 2'd1;
                end
                M_WORD: begin
                    recs[n] = mk(K_WORD, ts_next, tl_next, tln_next, tc_next); n = n + 2'd1;
                end
                default: ;
            endcase
            recs[n] = mk(K_END, off_next, '0, ln_next, sinc(col_next)); n = n + 2'd1;
            mode_next = M_IDLE; quote_next = 1'b0;
            ts_next = '0; tl_next = '0; tln_next = ONE; tc_next = '0;
            off_next = '0; ln_next = ONE; col_next = '0;
        end
        b_next.count = n;
        b_next.r0 = recs[0];
        b_next.r1 = recs[1];
        b_next.r2 = recs[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE; quote_reg <= 1'b0;
            ts_reg <= '0; tl_reg <= '0; tln_reg <= ONE; tc_reg <= '0;
            off_reg <= '0; ln_reg <= ONE; col_reg <= '0;
            bv_reg <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg <= mode_next; quote_reg <= quote_next;
                ts_reg <= ts_next; tl_reg <= tl_next; tln_reg <= tln_next; tc_reg <= tc_next;
                off_reg <= off_next; ln_reg <= ln_next; col_reg <= col_next;
            end
            if (in_ready) bv_reg <= accept && (b_next.count != 2'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) b_reg <= b_next;
    end
endmodule

FILE: rtl/bst_back.sv
module bst_back import bst_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  bundle_t     q_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_token_kind,
    output logic [15:0] m_start_offset,
    output logic [15:0] m_token_length,
    output logic [15:0] m_line_number,
    output logic [15:0] m_column_number,
    output logic        m_run_last
);
    // Two-entry queue of byte bundles, then serialization one record a cycle while m_ready is high.
    bundle_t    fifo_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic [1:0] idx_reg;
    bundle_t    head;
    rec_t       cur;
    logic       pop, push, last;

    assign head    = fifo_reg[rp_reg];
    assign q_ready = (cnt_reg != 2'd2);
    assign push    = q_valid && q_ready;
    assign m_valid = (cnt_reg != 2'd0);
    assign last    = (idx_reg == head.count - 2'd1);
    assign pop     = m_valid && m_ready && last;

    always_comb begin
        case (idx_reg)
            2'd0:    cur = head.r0;
            2'd1:    cur = head.r1;
            default: cur = head.r2;
        endcase
    end

    assign m_token_kind    = cur.kind;
    assign m_start_offset  = cur.offset;
    assign m_token_length  = cur.length;
    assign m_line_number   = cur.line;
    assign m_column_number = cur.column;
    assign m_run_last      = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0; idx_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
            if (m_valid && m_ready) idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) fifo_reg[wp_reg] <= q_data;
    end
endmodule

FILE: rtl/byte_stream_tokenizer.sv
// Byte stream tokenizer. One source byte is accepted per cycle on the s_ channel while
// s_ready is high; token records come out on the m_ channel, one per cycle while m_ready
// is high, with m_run_last marking the final record caused by a byte (up to three per
// byte, the last of a stream always an end token). The front end scans each byte and
// hands the records it causes to a two-entry queue; the back end plays them out. Sustained
// input rate is one byte per cycle while bytes cause at most one record each and m_ready
// is high; a byte causing several records keeps the single output port busy while they
// are played out. Counters saturate at 2^COUNT_BITS-1 and fields carry their low 16 bits.
module byte_stream_tokenizer import bst_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_stream_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_token_kind,
    output logic [15:0] m_start_offset,
    output logic [15:0] m_token_length,
    output logic [15:0] m_line_number,
    output logic [15:0] m_column_number,
    output logic        m_run_last
);
    logic    q_valid, q_ready;
    bundle_t q_data;

    // Front end: scanner state, position counters and record building.
    bst_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .in_byte(s_data_byte), .in_end(s_stream_end),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    // Back end: queue and record serializer.
    bst_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_token_kind(m_token_kind), .m_start_offset(m_start_offset),
        .m_token_length(m_token_length), .m_line_number(m_line_number),
        .m_column_number(m_column_number), .m_run_last(m_run_last)
    );
endmodule

FILE: rtl/bst_checker.sv
`include "byte_stream_tokenizer_macros.svh"
module bst_checker import bst_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [4:0] m_token_kind,
    input logic [15:0] m_line_number,
    input logic       m_run_last
);
    `BST_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_token_kind), "output item dropped or changed while stalled")
    `BST_ASSERT_ALWAYS(a_kind, aclk, aresetn, !m_valid || m_token_kind <= K_UNKNOWN, "token kind out of range")
    `BST_ASSERT_ALWAYS(a_end_last, aclk, aresetn, !m_valid || m_token_kind != K_END || m_run_last, "end token not last of its run")
    `BST_ASSERT_ALWAYS(a_line, aclk, aresetn, !m_valid || m_line_number != 16'd0, "line number zero")
endmodule

bind byte_stream_tokenizer bst_checker u_bst_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_token_kind(m_token_kind), .m_line_number(m_line_number), .m_run_last(m_run_last)
);
